/* rtl/core/hsv_to_rgb_with_brightness_macros.svh */
// Assertion macros for the HSV-to-RGB converter.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef HSV_TO_RGB_WITH_BRIGHTNESS_MACROS_SVH
`define HSV_TO_RGB_WITH_BRIGHTNESS_MACROS_SVH

// Same-cycle implication, checked out of reset
`define HTRB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define HTRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/htrb_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, types, sector codes and reciprocal constants for the
// HSV-to-RGB converter. No dependencies.
package htrb_pkg;

    localparam int HUE_W = 15;
    localparam int CH_W  = 8;
    localparam int BRT_W = 7;
    localparam int QUO_W = 10;   // hue / 60 degrees, at most 546
    localparam int SEC_W = 3;

    localparam int DEG_PER_SECTOR = 60;
    localparam int SECTORS        = 6;
    localparam int CH_MAX         = 255;

    localparam logic [BRT_W-1:0] BRT_MAX = 7'd100;

    // floor(x / d) == (x * MUL) >> SH over the value ranges used here
    localparam int DIV60_MUL    = 34953;     // x < 2^15
    localparam int DIV60_SH     = 21;
    localparam int DIV6_MUL     = 683;       // x < 2^11
    localparam int DIV6_SH      = 12;
    localparam int DIV255_MUL   = 32897;     // x <= 255 * 255
    localparam int DIV255_SH    = 23;
    localparam int DIV15300_MUL = 4491470;   // x <= 255 * 15300
    localparam int DIV15300_SH  = 36;
    localparam int DIV100_MUL   = 41944;     // x <= 255 * 100
    localparam int DIV100_SH    = 22;

    typedef logic [SEC_W-1:0] sector_t;
    typedef logic [CH_W-1:0]  chan_t;

    // 60-degree sectors of the hue circle
    localparam sector_t SEC_RED_YEL = 3'd0;
    localparam sector_t SEC_YEL_GRN = 3'd1;
    localparam sector_t SEC_GRN_CYN = 3'd2;
    localparam sector_t SEC_CYN_BLU = 3'd3;
    localparam sector_t SEC_BLU_MAG = 3'd4;
    localparam sector_t SEC_MAG_RED = 3'd5;

    // Standard HSV terms of one item plus its sector
    typedef struct packed {
        sector_t sector;
        chan_t   v;
        chan_t   p;
        chan_t   q;
        chan_t   t;
    } term_t;

endpackage

/* rtl/core/htrb_hsv_if.sv */
`timescale 1ns / 1ps
// Input channel: one HSV color per item with valid/ready handshake.
// Depends on htrb_pkg.
interface htrb_hsv_if;
    import htrb_pkg::*;

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_degrees;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  value_level;

    modport source (output valid, hue_degrees, saturation, value_level, input ready);
    modport sink   (input valid, hue_degrees, saturation, value_level, output ready);
endinterface

/* rtl/core/htrb_rgb_if.sv */
`timescale 1ns / 1ps
// Output channel: one scaled RGB color per item with valid/ready handshake.
// Depends on htrb_pkg.
interface htrb_rgb_if;
    import htrb_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* rtl/core/htrb_sector.sv */
`timescale 1ns / 1ps
// Three-stage hue splitter: sector number (mod 6) and position in sector.
// Depends on htrb_pkg and htrb_hsv_if.
module htrb_sector #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    htrb_hsv_if.sink                    hsv,
    output logic                        sec_valid,
    input  logic                        sec_ready,
    output htrb_pkg::sector_t           sector,
    output logic [6+HUE_FRAC_BITS-1:0]  rem,
    output htrb_pkg::chan_t             sat,
    output htrb_pkg::chan_t             val
);
    import htrb_pkg::*;

    localparam int REM_W  = 6 + HUE_FRAC_BITS;
    localparam int DEG_W  = HUE_W - HUE_FRAC_BITS;
    localparam int QP_W   = DEG_W + 16;
    localparam int Q6P_W  = QUO_W + 10;
    localparam int Q6_W   = 7;
    localparam int OFF_W  = QUO_W + 6 + HUE_FRAC_BITS;

    // Stage valids and enables; a stage moves when empty or drained below
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic s1_en, s2_en, s3_en;

    assign s3_en     = !s3_vld_reg || sec_ready;
    assign s2_en     = !s2_vld_reg || s3_en;
    assign s1_en     = !s1_vld_reg || s2_en;
    assign hsv.ready = s1_en;
    assign sec_valid = s3_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_en) s1_vld_reg <= hsv.valid;
            if (s2_en) s2_vld_reg <= s1_vld_reg;
            if (s3_en) s3_vld_reg <= s2_vld_reg;
        end
    end

    // Stage 1: whole degrees divided by 60
    logic [DEG_W-1:0] deg;
    logic [QP_W-1:0]  quo_prod;
    logic [QUO_W-1:0] quo_next;
    logic [HUE_W-1:0] s1_hue_reg;
    logic [QUO_W-1:0] s1_quo_reg;
    chan_t            s1_sat_reg, s1_val_reg;

    assign deg      = hsv.hue_degrees[HUE_W-1:HUE_FRAC_BITS];
    assign quo_prod = QP_W'(deg) * QP_W'(DIV60_MUL);
    assign quo_next = QUO_W'(quo_prod >> DIV60_SH);

    always_ff @(posedge clk)
    begin
        if (s1_en && hsv.valid)
        begin
            s1_hue_reg <= hsv.hue_degrees;
            s1_quo_reg <= quo_next;
            s1_sat_reg <= hsv.saturation;
            s1_val_reg <= hsv.value_level;
        end
    end

    // Stage 2: quotient by 6, remainder inside the sector
    logic [Q6P_W-1:0] q6_prod;
    logic [Q6_W-1:0]  q6_next;
    logic [OFF_W-1:0] off;
    logic [REM_W-1:0] rem_next;
    logic [QUO_W-1:0] s2_quo_reg;
    logic [Q6_W-1:0]  s2_q6_reg;
    logic [REM_W-1:0] s2_rem_reg;
    chan_t            s2_sat_reg, s2_val_reg;

    assign q6_prod  = Q6P_W'(s1_quo_reg) * Q6P_W'(DIV6_MUL);
    assign q6_next  = Q6_W'(q6_prod >> DIV6_SH);
    assign off      = (OFF_W'(s1_quo_reg) * OFF_W'(DEG_PER_SECTOR)) << HUE_FRAC_BITS;
    assign rem_next = REM_W'(OFF_W'(s1_hue_reg) - off);

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_vld_reg)
        begin
            s2_quo_reg <= s1_quo_reg;
            s2_q6_reg  <= q6_next;
            s2_rem_reg <= rem_next;
            s2_sat_reg <= s1_sat_reg;
            s2_val_reg <= s1_val_reg;
        end
    end

    // Stage 3: sector = quotient mod 6
    sector_t          sector_next;
    sector_t          s3_sector_reg;
    logic [REM_W-1:0] s3_rem_reg;
    chan_t            s3_sat_reg, s3_val_reg;

    assign sector_next = SEC_W'(s2_quo_reg - QUO_W'(s2_q6_reg) * QUO_W'(SECTORS));

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_vld_reg)
        begin
            s3_sector_reg <= sector_next;
            s3_rem_reg    <= s2_rem_reg;
            s3_sat_reg    <= s2_sat_reg;
            s3_val_reg    <= s2_val_reg;
        end
    end

    assign sector = s3_sector_reg;
    assign rem    = s3_rem_reg;
    assign sat    = s3_sat_reg;
    assign val    = s3_val_reg;

endmodule

/* rtl/core/htrb_terms.sv */
`timescale 1ns / 1ps
// Three-stage datapath for the HSV terms p, q and t, truncated toward zero.
// Depends on htrb_pkg.
module htrb_terms #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sec_valid,
    output logic                        sec_ready,
    input  htrb_pkg::sector_t           sector,
    input  logic [6+HUE_FRAC_BITS-1:0]  rem,
    input  htrb_pkg::chan_t             sat,
    input  htrb_pkg::chan_t             val,
    output logic                        term_valid,
    input  logic                        term_ready,
    output htrb_pkg::term_t             term
);
    import htrb_pkg::*;

    localparam int REM_W = 6 + HUE_FRAC_BITS;
    localparam int SPAN  = DEG_PER_SECTOR << HUE_FRAC_BITS;
    localparam int DEN_W = 14 + HUE_FRAC_BITS;
    localparam int DENOM = CH_MAX * SPAN;
    localparam int XP_W  = DEN_W + CH_W;
    localparam int X_W   = 22;               // v * 255 * 60 fits
    localparam int PP_W  = 2 * CH_W;
    localparam int PD_W  = 32;
    localparam int QD_W  = X_W + 23;

    logic t1_vld_reg, t2_vld_reg, t3_vld_reg;
    logic t1_en, t2_en, t3_en;

    assign t3_en      = !t3_vld_reg || term_ready;
    assign t2_en      = !t2_vld_reg || t3_en;
    assign t1_en      = !t1_vld_reg || t2_en;
    assign sec_ready  = t1_en;
    assign term_valid = t3_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_vld_reg <= 1'b0;
            t2_vld_reg <= 1'b0;
            t3_vld_reg <= 1'b0;
        end
        else
        begin
            if (t1_en) t1_vld_reg <= sec_valid;
            if (t2_en) t2_vld_reg <= t1_vld_reg;
            if (t3_en) t3_vld_reg <= t2_vld_reg;
        end
    end

    // Stage 1: f*s and (1-f)*s scaled by the sector span, and v*(255-s)
    logic [REM_W-1:0] rem_inv;
    logic [DEN_W-1:0] rs_next, trs_next;
    logic [PP_W-1:0]  pp_next;
    sector_t          t1_sector_reg;
    chan_t            t1_v_reg;
    logic [DEN_W-1:0] t1_rs_reg, t1_trs_reg;
    logic [PP_W-1:0]  t1_pp_reg;

    assign rem_inv  = REM_W'(SPAN) - rem;
    assign rs_next  = DEN_W'(rem) * DEN_W'(sat);
    assign trs_next = DEN_W'(rem_inv) * DEN_W'(sat);
    assign pp_next  = PP_W'(val) * PP_W'(CH_W'(CH_MAX) - sat);

    always_ff @(posedge clk)
    begin
        if (t1_en && sec_valid)
        begin
            t1_sector_reg <= sector;
            t1_v_reg      <= val;
            t1_rs_reg     <= rs_next;
            t1_trs_reg    <= trs_next;
            t1_pp_reg     <= pp_next;
        end
    end

    // Stage 2: numerators of q and t, p = v*(255-s)/255
    logic [DEN_W-1:0] nq, nt;
    logic [XP_W-1:0]  xq_prod, xt_prod;
    logic [PD_W-1:0]  p_prod;
    sector_t          t2_sector_reg;
    chan_t            t2_v_reg, t2_p_reg;
    logic [X_W-1:0]   t2_xq_reg, t2_xt_reg;

    assign nq      = DEN_W'(DENOM) - t1_rs_reg;
    assign nt      = DEN_W'(DENOM) - t1_trs_reg;
    assign xq_prod = XP_W'(t1_v_reg) * XP_W'(nq);
    assign xt_prod = XP_W'(t1_v_reg) * XP_W'(nt);
    assign p_prod  = PD_W'(t1_pp_reg) * PD_W'(DIV255_MUL);

    always_ff @(posedge clk)
    begin
        if (t2_en && t1_vld_reg)
        begin
            t2_sector_reg <= t1_sector_reg;
            t2_v_reg      <= t1_v_reg;
            t2_p_reg      <= CH_W'(p_prod >> DIV255_SH);
            // dividing by 2^F first leaves a divide by 255*60
            t2_xq_reg     <= X_W'(xq_prod >> HUE_FRAC_BITS);
            t2_xt_reg     <= X_W'(xt_prod >> HUE_FRAC_BITS);
        end
    end

    // Stage 3: q and t by reciprocal of 15300
    logic [QD_W-1:0] q_prod, t_prod;
    term_t           term_next;
    term_t           t3_term_reg;

    assign q_prod = QD_W'(t2_xq_reg) * QD_W'(DIV15300_MUL);
    assign t_prod = QD_W'(t2_xt_reg) * QD_W'(DIV15300_MUL);

    always_comb
    begin
        term_next.sector = t2_sector_reg;
        term_next.v      = t2_v_reg;
        term_next.p      = t2_p_reg;
        term_next.q      = CH_W'(q_prod >> DIV15300_SH);
        term_next.t      = CH_W'(t_prod >> DIV15300_SH);
    end

    always_ff @(posedge clk)
    begin
        if (t3_en && t2_vld_reg)
        begin
            t3_term_reg <= term_next;
        end
    end

    assign term = t3_term_reg;

endmodule

/* rtl/core/htrb_scale.sv */
`timescale 1ns / 1ps
// Two-stage channel mux and brightness scaling (c * percent / 100).
// Depends on htrb_pkg and htrb_rgb_if.
module htrb_scale (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        term_valid,
    output logic                        term_ready,
    input  htrb_pkg::term_t             term,
    input  logic [htrb_pkg::BRT_W-1:0]  brightness,
    htrb_rgb_if.source                  rgb
);
    import htrb_pkg::*;

    localparam int PROD_W = CH_W + BRT_W;
    localparam int DP_W   = PROD_W + 16;

    logic b1_vld_reg, b2_vld_reg;
    logic b1_en, b2_en;

    assign b2_en      = !b2_vld_reg || rgb.ready;
    assign b1_en      = !b1_vld_reg || b2_en;
    assign term_ready = b1_en;
    assign rgb.valid  = b2_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
        end
        else
        begin
            if (b1_en) b1_vld_reg <= term_valid;
            if (b2_en) b2_vld_reg <= b1_vld_reg;
        end
    end

    // Stage 1: sector picks the channel terms, then scale by percent
    chan_t             red_sel, green_sel, blue_sel;
    logic [PROD_W-1:0] b1_red_reg, b1_green_reg, b1_blue_reg;

    always_comb
    begin
        unique case (term.sector)
            SEC_RED_YEL:
            begin
                red_sel = term.v; green_sel = term.t; blue_sel = term.p;
            end
            SEC_YEL_GRN:
            begin
                red_sel = term.q; green_sel = term.v; blue_sel = term.p;
            end
            SEC_GRN_CYN:
            begin
                red_sel = term.p; green_sel = term.v; blue_sel = term.t;
            end
            SEC_CYN_BLU:
            begin
                red_sel = term.p; green_sel = term.q; blue_sel = term.v;
            end
            SEC_BLU_MAG:
            begin
                red_sel = term.t; green_sel = term.p; blue_sel = term.v;
            end
            default:
            begin
                // magenta-to-red sector
                red_sel = term.v; green_sel = term.p; blue_sel = term.q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (b1_en && term_valid)
        begin
            b1_red_reg   <= PROD_W'(red_sel) * PROD_W'(brightness);
            b1_green_reg <= PROD_W'(green_sel) * PROD_W'(brightness);
            b1_blue_reg  <= PROD_W'(blue_sel) * PROD_W'(brightness);
        end
    end

    // Stage 2: divide by 100 through reciprocal
    logic [DP_W-1:0] red_prod, green_prod, blue_prod;
    chan_t           red_reg, green_reg, blue_reg;

    assign red_prod   = DP_W'(b1_red_reg) * DP_W'(DIV100_MUL);
    assign green_prod = DP_W'(b1_green_reg) * DP_W'(DIV100_MUL);
    assign blue_prod  = DP_W'(b1_blue_reg) * DP_W'(DIV100_MUL);

    always_ff @(posedge clk)
    begin
        if (b2_en && b1_vld_reg)
        begin
            red_reg   <= CH_W'(red_prod >> DIV100_SH);
            green_reg <= CH_W'(green_prod >> DIV100_SH);
            blue_reg  <= CH_W'(blue_prod >> DIV100_SH);
        end
    end

    assign rgb.red_out   = red_reg;
    assign rgb.green_out = green_reg;
    assign rgb.blue_out  = blue_reg;

endmodule

/* rtl/core/hsv_to_rgb_with_brightness.sv */
`timescale 1ns / 1ps
// HSV-to-RGB converter with brightness scaling, top level.
// Depends on htrb_pkg, htrb_hsv_if, htrb_rgb_if, htrb_sector, htrb_terms,
// htrb_scale and hsv_to_rgb_with_brightness_macros.svh.
//
// Converts one HSV color per item to 8-bit RGB using the six-sector terms
// v, p, q, t (each truncated toward zero) and then scales every channel by
// brightness_percent / 100, truncated. The pipeline has eight register
// stages, and a new item can be accepted every cycle while the output
// accepts results. Ready is combinational from the output backwards through
// the stages, so a stalled output only holds the stages that carry items;
// empty stages keep filling. Brightness is written through cfg_we /
// cfg_wdata; values above 100 are stored as 100, reset value is 100.
// Write it only while no items are in flight.
`include "hsv_to_rgb_with_brightness_macros.svh"

module hsv_to_rgb_with_brightness #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    htrb_hsv_if.sink                    hsv_in,
    htrb_rgb_if.source                  rgb_out,
    input  logic                        cfg_we,
    input  logic [htrb_pkg::BRT_W-1:0]  cfg_wdata
);
    import htrb_pkg::*;

    localparam int REM_W = 6 + HUE_FRAC_BITS;

    // Brightness register, clamped on write
    logic [BRT_W-1:0] brightness_reg;
    logic [BRT_W-1:0] brightness_next;

    assign brightness_next = (cfg_wdata > BRT_MAX) ? BRT_MAX : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRT_MAX;
        end
        else if (cfg_we)
        begin
            brightness_reg <= brightness_next;
        end
    end

    // Hue split
    logic             sec_valid, sec_ready;
    sector_t          sector;
    logic [REM_W-1:0] rem;
    chan_t            sat, val;

    htrb_sector #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv       (hsv_in),
        .sec_valid (sec_valid),
        .sec_ready (sec_ready),
        .sector    (sector),
        .rem       (rem),
        .sat       (sat),
        .val       (val)
    );

    // HSV terms
    logic  term_valid, term_ready;
    term_t term;

    htrb_terms #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_terms (
        .clk        (clk),
        .rst_n      (rst_n),
        .sec_valid  (sec_valid),
        .sec_ready  (sec_ready),
        .sector     (sector),
        .rem        (rem),
        .sat        (sat),
        .val        (val),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term       (term)
    );

    // Channel select and brightness
    htrb_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .term_valid (term_valid),
        .term_ready (term_ready),
        .term       (term),
        .brightness (brightness_reg),
        .rgb        (rgb_out)
    );

    // Checks
    `HTRB_ASSERT_IMP(a_brt_range, 1'b1, brightness_reg <= BRT_MAX, "brightness above 100")
    `HTRB_ASSERT_NEXT(a_brt_clamp, cfg_we && (cfg_wdata > BRT_MAX),
                      brightness_reg == BRT_MAX, "brightness write not clamped")
    `HTRB_ASSERT_IMP(a_no_bubble, rgb_out.ready, hsv_in.ready,
                     "pipeline refuses item while output drains")

endmodule
